FILE: src/fit_strategy_segment_allocator_unit_assert.svh
// assertion macros for the allocator control file
`ifndef FIT_STRATEGY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_STRATEGY_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fsa assertion failed");
`define FSA_ASSERT_NORST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("fsa assertion failed");
`else
`define FSA_ASSERT(name, clk, rst, prop)
`define FSA_ASSERT_NORST(name, clk, prop)
`endif
`endif

FILE: src/fsa_pkg.sv
`timescale 1ns / 1ps
package fsa_pkg;
  localparam int NSEG   = 64;
  localparam int SIZE_W = 16;
  localparam int IDX_W  = $clog2(NSEG);
  localparam int CNT_W  = $clog2(NSEG + 1);

  localparam logic [SIZE_W-1:0] RESET_POOL  = SIZE_W'(65535);

  localparam logic [2:0] STRAT_NONE  = 3'd0;
  localparam logic [2:0] STRAT_FIRST = 3'd1;
  localparam logic [2:0] STRAT_BEST  = 3'd2;
  localparam logic [2:0] STRAT_WORST = 3'd3;
  localparam logic [2:0] STRAT_NEXT  = 3'd4;
  localparam logic [2:0] RESET_STRAT = STRAT_FIRST;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;

  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_POOL     = 2'd1;

  typedef enum logic [1:0] {CMD_NONE, CMD_INIT, CMD_ALLOC, CMD_FREE} cmd_t;
  typedef enum logic [2:0] {S_IDLE, S_PICK, S_UPDATE, S_STATS, S_DONE} fsm_t;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } seg_t;

  // partial results carried down the chain
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] start;
    logic              gfound;
    logic [IDX_W-1:0]  gidx;
    logic [SIZE_W-1:0] gsize;
    logic [SIZE_W-1:0] gstart;
    logic [CNT_W-1:0]  holes;
    logic [SIZE_W-1:0] abytes;
    logic [SIZE_W-1:0] fbytes;
    logic [SIZE_W-1:0] largest;
    logic [CNT_W-1:0]  small_cnt;
    logic              isalloc;
  } tok_t;

  typedef struct packed {
    cmd_t              op;
    logic              split;
    logic [IDX_W-1:0]  sel;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] rem_start;
    logic [SIZE_W-1:0] rem_size;
    logic [SIZE_W-1:0] baddr;
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W-1:0] pool;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  cur;
    logic [2:0]        strat;
  } ctl_t;
endpackage

FILE: src/fsa_cell.sv
`timescale 1ns / 1ps
module fsa_cell import fsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  ctl_t             ctl,
  input  seg_t             prev_seg,
  input  tok_t             tok_in,
  output seg_t             seg,
  output tok_t             tok_out
);
  logic [CNT_W-1:0] idx_w;
  logic [CNT_W-1:0] sel_p1;
  logic             vld;
  logic             fit;
  tok_t             tok_next;

  assign idx_w  = {1'b0, idx};
  assign sel_p1 = {1'b0, ctl.sel} + CNT_W'(1);
  assign vld    = idx_w < ctl.count;
  assign fit    = vld && !seg.used && (seg.size >= ctl.req);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.start <= '0;
      seg.size  <= (idx == '0) ? RESET_POOL : '0;
      seg.used  <= 1'b0;
    end else begin
      unique case (ctl.op)
        CMD_INIT: begin
          seg.start <= '0;
          seg.size  <= (idx == '0) ? ctl.pool : '0;
          seg.used  <= 1'b0;
        end
        CMD_ALLOC: begin
          if (idx == ctl.sel) begin
            seg.size <= ctl.req;
            seg.used <= 1'b1;
          end else if (ctl.split && idx_w == sel_p1) begin
            seg.start <= ctl.rem_start;
            seg.size  <= ctl.rem_size;
            seg.used  <= 1'b0;
          end else if (ctl.split && idx_w > sel_p1) begin
            // open a slot for the remainder
            seg <= prev_seg;
          end
        end
        CMD_FREE: begin
          if (vld && seg.start == ctl.baddr) seg.used <= 1'b0;
        end
        CMD_NONE: ;
      endcase
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (fit) begin
      if (!tok_in.found ||
          (ctl.strat == STRAT_BEST && seg.size < tok_in.size) ||
          (ctl.strat == STRAT_WORST && seg.size > tok_in.size)) begin
        tok_next.found = 1'b1;
        tok_next.idx   = idx;
        tok_next.size  = seg.size;
        tok_next.start = seg.start;
      end
      if (!tok_in.gfound && idx >= ctl.cur) begin
        tok_next.gfound = 1'b1;
        tok_next.gidx   = idx;
        tok_next.gsize  = seg.size;
        tok_next.gstart = seg.start;
      end
    end
    if (vld) begin
      if (seg.used) begin
        tok_next.abytes = tok_in.abytes + seg.size;
      end else begin
        tok_next.holes  = tok_in.holes + CNT_W'(1);
        tok_next.fbytes = tok_in.fbytes + seg.size;
        if (seg.size > tok_in.largest) tok_next.largest = seg.size;
        if (seg.size < ctl.lim) tok_next.small_cnt = tok_in.small_cnt + CNT_W'(1);
      end
      if (seg.used && seg.start == ctl.baddr) tok_next.isalloc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end
endmodule

FILE: src/fsa_ctrl.sv
`timescale 1ns / 1ps
`include "fit_strategy_segment_allocator_unit_assert.svh"
module fsa_ctrl import fsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [SIZE_W-1:0] block_addr,
  input  logic [SIZE_W-1:0] small_limit,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  tok_t              tok,
  output ctl_t              ctl,
  output logic              busy,
  output logic              done,
  output logic              ok,
  output logic [SIZE_W-1:0] alloc_addr,
  output logic [CNT_W-1:0]  hole_count,
  output logic [SIZE_W-1:0] used_size_sum,
  output logic [SIZE_W-1:0] free_size_sum,
  output logic [SIZE_W-1:0] largest_free,
  output logic [CNT_W-1:0]  small_free_count,
  output logic              addr_is_allocated
);
  fsm_t              state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        kind_q;
  logic [SIZE_W-1:0] req_q, baddr_q, lim_q;
  logic [2:0]        strategy;
  logic [SIZE_W-1:0] pool_size;
  logic [CNT_W-1:0]  seg_count;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  sel;
  logic [SIZE_W-1:0] sel_size, sel_start;
  logic              alloc_ok, split, have;

  logic              have_c, split_c, alloc_ok_c, pass_end, do_init;
  logic [IDX_W-1:0]  sel_c;
  logic [SIZE_W-1:0] size_c, start_c;

  assign pass_end = (cnt == CNT_W'(NSEG));
  assign do_init  = cfg_we && (cfg_index == REG_STRATEGY || cfg_index == REG_POOL);

  always_comb begin
    have_c  = 1'b0;
    sel_c   = tok.idx;
    size_c  = tok.size;
    start_c = tok.start;
    unique case (strategy)
      STRAT_FIRST, STRAT_BEST, STRAT_WORST: have_c = tok.found;
      STRAT_NEXT: begin
        // wrap to the lowest fit when nothing fits from the cursor on
        if (tok.gfound) begin
          have_c  = 1'b1;
          sel_c   = tok.gidx;
          size_c  = tok.gsize;
          start_c = tok.gstart;
        end else begin
          have_c = tok.found;
        end
      end
      default: have_c = 1'b0;
    endcase
    split_c    = size_c != req_q;
    alloc_ok_c = have_c && (req_q != '0) && (!split_c || seg_count < CNT_W'(NSEG));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_PICK;
      S_PICK:   if (pass_end) state_next = S_UPDATE;
      S_UPDATE: state_next = S_STATS;
      S_STATS:  if (pass_end) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = state != S_IDLE;
    done = state == S_DONE;
    ctl.op = CMD_NONE;
    if (do_init) begin
      ctl.op = CMD_INIT;
    end else if (state == S_UPDATE) begin
      if (kind_q == KIND_ALLOC) begin
        if (alloc_ok) ctl.op = CMD_ALLOC;
      end else if (kind_q == KIND_FREE) begin
        ctl.op = CMD_FREE;
      end
    end
    ctl.split     = split;
    ctl.sel       = sel;
    ctl.req       = req_q;
    ctl.rem_start = sel_start + req_q;
    ctl.rem_size  = sel_size - req_q;
    ctl.baddr     = baddr_q;
    ctl.lim       = lim_q;
    ctl.pool      = (cfg_index == REG_POOL) ? cfg_data : pool_size;
    ctl.count     = seg_count;
    ctl.cur       = ({1'b0, cursor} < seg_count) ? cursor : '0;
    ctl.strat     = strategy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      strategy  <= RESET_STRAT;
      pool_size <= RESET_POOL;
      seg_count <= CNT_W'(1);
      cursor    <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CNT_W'(1);
      if (cfg_we) begin
        if (cfg_index == REG_STRATEGY) strategy <= cfg_data[2:0];
        if (cfg_index == REG_POOL) pool_size <= cfg_data;
      end
      if (do_init) begin
        seg_count <= CNT_W'(1);
        cursor    <= '0;
      end else if (state == S_UPDATE && kind_q == KIND_ALLOC) begin
        if (alloc_ok && split) seg_count <= seg_count + CNT_W'(1);
        if (strategy == STRAT_NEXT) begin
          // the search moves the cursor even when a full table refuses the split
          if (have && req_q != '0) cursor <= sel;
        end else if (alloc_ok && split && cursor > sel && {1'b0, cursor} < seg_count) begin
          cursor <= cursor + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      kind_q  <= kind;
      req_q   <= request_size;
      baddr_q <= block_addr;
      lim_q   <= small_limit;
    end
    if (state == S_PICK && pass_end) begin
      sel       <= sel_c;
      sel_size  <= size_c;
      sel_start <= start_c;
      alloc_ok  <= alloc_ok_c;
      split     <= split_c;
      have      <= have_c;
    end
    if (state == S_STATS && pass_end) begin
      ok                <= (kind_q == KIND_ALLOC) ? alloc_ok : 1'b1;
      alloc_addr        <= (kind_q == KIND_ALLOC && alloc_ok) ? sel_start : '0;
      hole_count        <= tok.holes;
      used_size_sum     <= tok.abytes;
      free_size_sum     <= tok.fbytes;
      largest_free      <= tok.largest;
      small_free_count  <= tok.small_cnt;
      addr_is_allocated <= tok.isalloc;
    end
  end

  `FSA_ASSERT(a_done_pulse, clk, rst, done |=> !done)
  `FSA_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `FSA_ASSERT(a_fail_addr, clk, rst, (done && !ok) |-> (alloc_addr == '0))
  `FSA_ASSERT(a_holes_bound, clk, rst, done |-> (hole_count <= seg_count))
  `FSA_ASSERT(a_count_range, clk, rst, (seg_count != '0) && (seg_count <= CNT_W'(NSEG)))
endmodule

FILE: src/fit_strategy_segment_allocator_unit.sv
`timescale 1ns / 1ps
// done rises after a request is taken, once the block has made a search pass
// through the cell chain, an update step, a statistics pass and the result state
// a new request is taken only when idle, after the previous one has finished
// reset: strategy first fit, pool 65535 bytes, table holds one free segment
// results hold on the outputs after done, which is high for one cycle; the receiver cannot stall
module fit_strategy_segment_allocator_unit import fsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic [1:0]        kind,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [SIZE_W-1:0] block_addr,
  input  logic [SIZE_W-1:0] small_limit,
  output logic              ok,
  output logic [SIZE_W-1:0] alloc_addr,
  output logic [CNT_W-1:0]  hole_count,
  output logic [SIZE_W-1:0] used_size_sum,
  output logic [SIZE_W-1:0] free_size_sum,
  output logic [SIZE_W-1:0] largest_free,
  output logic [CNT_W-1:0]  small_free_count,
  output logic              addr_is_allocated
);
  ctl_t ctl;
  seg_t segs [NSEG];
  tok_t toks [NSEG];

  fsa_ctrl u_ctrl (
    .clk, .rst, .start, .kind, .request_size, .block_addr, .small_limit,
    .cfg_we, .cfg_index, .cfg_data,
    .tok(toks[NSEG-1]), .ctl, .busy, .done, .ok, .alloc_addr, .hole_count,
    .used_size_sum, .free_size_sum, .largest_free, .small_free_count,
    .addr_is_allocated
  );

  for (genvar i = 0; i < NSEG; i++) begin : g_cell
    if (i == 0) begin : g_head
      fsa_cell u_cell (
        .clk, .rst, .idx(IDX_W'(i)), .ctl, .prev_seg('0), .tok_in('0),
        .seg(segs[i]), .tok_out(toks[i])
      );
    end else begin : g_body
      fsa_cell u_cell (
        .clk, .rst, .idx(IDX_W'(i)), .ctl, .prev_seg(segs[i-1]), .tok_in(toks[i-1]),
        .seg(segs[i]), .tok_out(toks[i])
      );
    end
  end
endmodule
